// ===== hw/rtl/iph_pkg.sv =====
// ----------------------------------------------------------------------------
// iph_pkg
// Shared types and constants for the interrupt priority heap: request and
// response payloads, default sizes, operation codes and slot map commands.
// ----------------------------------------------------------------------------
package iph_pkg;

    // default sizes
    localparam int DEF_NUM_SOURCES  = 14;
    localparam int DEF_PRIO_BITS    = 16;
    localparam int DEF_HANDLER_BITS = 32;

    // fixed field widths of the channels
    localparam int SRC_FIELD_W  = 4;
    localparam int PRIO_FIELD_W = 16;
    localparam int HAND_FIELD_W = 32;
    localparam int CNT_FIELD_W  = 4;

    // operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [SRC_FIELD_W-1:0]  source;
        logic [PRIO_FIELD_W-1:0] prio;
        logic [HAND_FIELD_W-1:0] handler;
    } t_req;

    typedef struct packed {
        logic [HAND_FIELD_W-1:0] old_handler;
        logic                    had_old;
        logic [CNT_FIELD_W-1:0]  entry_count;
        logic                    top_valid;
        logic [SRC_FIELD_W-1:0]  top_source;
        logic [HAND_FIELD_W-1:0] top_handler;
    } t_rsp;

    // write command to the source-to-slot map
    typedef struct packed {
        logic slot_we;
        logic pres_we;
        logic pres_val;
    } t_map_cmd;

endpackage

// ===== hw/rtl/iph_heap_ram.sv =====
// ----------------------------------------------------------------------------
// iph_heap_ram
// Heap entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iph_heap_ram
    import iph_pkg::*;
#(
    parameter int WIDTH = DEF_PRIO_BITS + DEF_HANDLER_BITS + $clog2(DEF_NUM_SOURCES),
    parameter int DEPTH = DEF_NUM_SOURCES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/iph_slot_map.sv =====
// ----------------------------------------------------------------------------
// iph_slot_map
// Source-to-slot map: heap slot of each source and a present bit per source,
// with registered read data.
// ----------------------------------------------------------------------------
module iph_slot_map
    import iph_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(NUM_SOURCES)-1:0] i_rd_src,
    output logic [$clog2(NUM_SOURCES)-1:0] o_rd_slot,
    output logic                           o_rd_present,
    input  t_map_cmd                       i_cmd,
    input  logic [$clog2(NUM_SOURCES)-1:0] i_wr_src,
    input  logic [$clog2(NUM_SOURCES)-1:0] i_wr_slot
);

    localparam int IW = $clog2(NUM_SOURCES);

    logic [NUM_SOURCES-1:0] r_present;
    logic [IW-1:0]          r_slot [NUM_SOURCES];
    logic [IW-1:0]          r_rd_slot;
    logic                   r_rd_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.pres_we) begin
            r_present[i_wr_src] <= i_cmd.pres_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_we) begin
            r_slot[i_wr_src] <= i_wr_slot;
        end
    end

    // read data shows up in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_slot    <= r_slot[i_rd_src];
        r_rd_present <= r_present[i_rd_src];
    end

    assign o_rd_slot    = r_rd_slot;
    assign o_rd_present = r_rd_present;

endmodule

// ===== hw/rtl/interrupt_priority_heap.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_heap
// Indexed max-heap of interrupt handlers, one entry per source.
// ----------------------------------------------------------------------------
// One request channel (i_in_valid / o_in_stall, payload i_in) carries add or
// remove requests for a source; one response channel (o_out_valid /
// i_out_stall, payload o_out) returns one response per request with the
// previous handler, the entry count and the current top entry.
// Requests are handled one at a time by a sequencer around the heap RAM
// (one read or one write per cycle, registered read data).
// Removal moves the last entry into the freed slot and sifts it down, then
// up; an add then appends the new entry and sifts it up. Each up step is a
// parent read and a compare, each down step a left child read, a right
// child read and a compare; the heap depth bounds the number of steps.
// A new transfer is only taken in the idle state.
// o_in_stall is high from the transfer of a request until its response is
// loaded into the output register. The output register holds the response
// while i_out_stall is high; the next request can be taken meanwhile, and
// the sequencer waits at its last step if the register is still full.
// Reset (synchronous, active low) empties the heap and marks every source
// absent; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interrupt_priority_heap
    import iph_pkg::*;
#(
    parameter int NUM_SOURCES  = DEF_NUM_SOURCES,
    parameter int PRIO_BITS    = DEF_PRIO_BITS,
    parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out
);

    localparam int IW   = $clog2(NUM_SOURCES);
    localparam int CNTW = $clog2(NUM_SOURCES + 1);
    localparam int CW   = IW + 2;
    localparam int EW   = PRIO_BITS + HANDLER_BITS + IW;
    localparam int PXW  = (PRIO_BITS > PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOOK     = 4'd1;
    localparam logic [3:0] S_DEL_OLD  = 4'd2;
    localparam logic [3:0] S_DEL_LAST = 4'd3;
    localparam logic [3:0] S_DN_L     = 4'd4;
    localparam logic [3:0] S_DN_R     = 4'd5;
    localparam logic [3:0] S_DN_CMP   = 4'd6;
    localparam logic [3:0] S_UP       = 4'd7;
    localparam logic [3:0] S_UP_CMP   = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;
    localparam logic [3:0] S_INS_CHK  = 4'd10;
    localparam logic [3:0] S_TOP      = 4'd11;
    localparam logic [3:0] S_TOP_W    = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    // control state
    logic [3:0]      r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_out_valid, n_out_valid;

    // request and work registers
    logic                    r_op, n_op;
    logic [IW-1:0]           r_src, n_src;
    logic                    r_in_range, n_in_range;
    logic [PRIO_BITS-1:0]    r_rprio, n_rprio;
    logic [HANDLER_BITS-1:0] r_rhand, n_rhand;
    logic [IW-1:0]           r_idx, n_idx;
    logic [PRIO_BITS-1:0]    r_cur_prio, n_cur_prio;
    logic [HANDLER_BITS-1:0] r_cur_hand, n_cur_hand;
    logic [IW-1:0]           r_cur_src, n_cur_src;
    logic [PRIO_BITS-1:0]    r_ch_prio, n_ch_prio;
    logic [HANDLER_BITS-1:0] r_ch_hand, n_ch_hand;
    logic [IW-1:0]           r_ch_src, n_ch_src;
    logic [IW-1:0]           r_ch_idx, n_ch_idx;
    logic                    r_has_r, n_has_r;
    logic                    r_phase_ins, n_phase_ins;
    logic [HANDLER_BITS-1:0] r_old_hand, n_old_hand;
    logic                    r_had, n_had;
    t_rsp                    r_out, n_out;

    // heap ram port
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [PRIO_BITS-1:0]    rd_prio;
    logic [HANDLER_BITS-1:0] rd_hand;
    logic [IW-1:0]           rd_src;

    // slot map port
    t_map_cmd      map_cmd;
    logic [IW-1:0] map_wr_src, map_wr_slot;
    logic [IW-1:0] map_rd_slot;
    logic          map_rd_present;

    // input conditioning
    logic [PXW-1:0]       in_prio_ext, prio_max_ext, in_prio_sat;
    logic                 in_ok;

    // index arithmetic
    logic [CW-1:0]   c_left, c_right, cnt_ext;
    logic [CNTW-1:0] cnt_dec;
    logic [IW-1:0]   parent_idx;
    logic            take_r;

    assign rd_prio = ram_rdata[EW-1 -: PRIO_BITS];
    assign rd_hand = ram_rdata[IW +: HANDLER_BITS];
    assign rd_src  = ram_rdata[IW-1:0];

    assign in_prio_ext  = PXW'(i_in.prio);
    assign prio_max_ext = PXW'({PRIO_BITS{1'b1}});
    assign in_prio_sat  = (in_prio_ext > prio_max_ext) ? prio_max_ext : in_prio_ext;
    assign in_ok        = (32'(i_in.source) < NUM_SOURCES);

    assign c_left     = CW'({r_idx, 1'b1});
    assign c_right    = c_left + CW'(1);
    assign cnt_ext    = CW'(r_count);
    assign cnt_dec    = r_count - CNTW'(1);
    assign parent_idx = (r_idx - IW'(1)) >> 1;
    assign take_r     = r_has_r && (rd_prio > r_ch_prio);

    iph_heap_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // map is addressed with the next source so its data is ready in S_LOOK
    iph_slot_map #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_src     (n_src),
        .o_rd_slot    (map_rd_slot),
        .o_rd_present (map_rd_present),
        .i_cmd        (map_cmd),
        .i_wr_src     (map_wr_src),
        .i_wr_slot    (map_wr_slot)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_src       = r_src;
        n_in_range  = r_in_range;
        n_rprio     = r_rprio;
        n_rhand     = r_rhand;
        n_idx       = r_idx;
        n_cur_prio  = r_cur_prio;
        n_cur_hand  = r_cur_hand;
        n_cur_src   = r_cur_src;
        n_ch_prio   = r_ch_prio;
        n_ch_hand   = r_ch_hand;
        n_ch_src    = r_ch_src;
        n_ch_idx    = r_ch_idx;
        n_has_r     = r_has_r;
        n_phase_ins = r_phase_ins;
        n_old_hand  = r_old_hand;
        n_had       = r_had;
        n_out       = r_out;

        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = '0;
        ram_wdata   = '0;
        map_cmd     = '0;
        map_wr_src  = r_src;
        map_wr_slot = r_idx;

        // response leaves the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in.op;
                    n_in_range = in_ok;
                    n_src      = in_ok ? IW'(i_in.source) : '0;
                    n_rprio    = PRIO_BITS'(in_prio_sat);
                    n_rhand    = HANDLER_BITS'(i_in.handler);
                    n_old_hand = '0;
                    n_had      = 1'b0;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_in_range) begin
                    n_state = S_TOP;
                end else if (map_rd_present) begin
                    n_idx     = map_rd_slot;
                    ram_re    = 1'b1;
                    ram_raddr = map_rd_slot;
                    n_state   = S_DEL_OLD;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_DEL_OLD: begin
                n_old_hand       = rd_hand;
                n_had            = 1'b1;
                map_cmd.pres_we  = 1'b1;
                map_cmd.pres_val = 1'b0;
                map_wr_src       = r_src;
                n_count          = cnt_dec;
                if (CNTW'(r_idx) < cnt_dec) begin
                    // refill the freed slot with the last entry
                    ram_re    = 1'b1;
                    ram_raddr = IW'(cnt_dec);
                    n_state   = S_DEL_LAST;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_DEL_LAST: begin
                n_cur_prio  = rd_prio;
                n_cur_hand  = rd_hand;
                n_cur_src   = rd_src;
                n_phase_ins = 1'b0;
                n_state     = S_DN_L;
            end
            S_DN_L: begin
                if (c_left >= cnt_ext) begin
                    n_state = S_UP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(c_left);
                    n_state   = S_DN_R;
                end
            end
            S_DN_R: begin
                n_ch_prio = rd_prio;
                n_ch_hand = rd_hand;
                n_ch_src  = rd_src;
                n_ch_idx  = IW'(c_left);
                n_has_r   = (c_right < cnt_ext);
                if (c_right < cnt_ext) begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(c_right);
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (take_r ? (rd_prio > r_cur_prio) : (r_ch_prio > r_cur_prio)) begin
                    // larger child moves up into the hole
                    ram_we          = 1'b1;
                    ram_waddr       = r_idx;
                    ram_wdata       = take_r ? ram_rdata : {r_ch_prio, r_ch_hand, r_ch_src};
                    map_cmd.slot_we = 1'b1;
                    map_wr_src      = take_r ? rd_src : r_ch_src;
                    map_wr_slot     = r_idx;
                    n_idx           = take_r ? (r_ch_idx + IW'(1)) : r_ch_idx;
                    n_state         = S_DN_L;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = parent_idx;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_cur_prio > rd_prio) begin
                    // parent moves down into the hole
                    ram_we          = 1'b1;
                    ram_waddr       = r_idx;
                    ram_wdata       = ram_rdata;
                    map_cmd.slot_we = 1'b1;
                    map_wr_src      = rd_src;
                    map_wr_slot     = r_idx;
                    n_idx           = parent_idx;
                    n_state         = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                ram_we          = 1'b1;
                ram_waddr       = r_idx;
                ram_wdata       = {r_cur_prio, r_cur_hand, r_cur_src};
                map_cmd.slot_we = 1'b1;
                map_wr_src      = r_cur_src;
                map_wr_slot     = r_idx;
                n_state         = r_phase_ins ? S_TOP : S_INS_CHK;
            end
            S_INS_CHK: begin
                if (r_op == OP_ADD && r_count < CNTW'(NUM_SOURCES)) begin
                    n_cur_prio       = r_rprio;
                    n_cur_hand       = r_rhand;
                    n_cur_src        = r_src;
                    n_idx            = IW'(r_count);
                    n_count          = r_count + CNTW'(1);
                    map_cmd.pres_we  = 1'b1;
                    map_cmd.pres_val = 1'b1;
                    map_wr_src       = r_src;
                    n_phase_ins      = 1'b1;
                    n_state          = S_UP;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                if (r_count != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_state   = S_TOP_W;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TOP_W: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.old_handler = HAND_FIELD_W'(r_old_hand);
                    n_out.had_old     = r_had;
                    n_out.entry_count = CNT_FIELD_W'(r_count);
                    n_out.top_valid   = (r_count != '0);
                    n_out.top_source  = (r_count != '0) ? SRC_FIELD_W'(rd_src) : '0;
                    n_out.top_handler = (r_count != '0) ? HAND_FIELD_W'(rd_hand) : '0;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_src       <= n_src;
        r_in_range  <= n_in_range;
        r_rprio     <= n_rprio;
        r_rhand     <= n_rhand;
        r_idx       <= n_idx;
        r_cur_prio  <= n_cur_prio;
        r_cur_hand  <= n_cur_hand;
        r_cur_src   <= n_cur_src;
        r_ch_prio   <= n_ch_prio;
        r_ch_hand   <= n_ch_hand;
        r_ch_src    <= n_ch_src;
        r_ch_idx    <= n_ch_idx;
        r_has_r     <= n_has_r;
        r_phase_ins <= n_phase_ins;
        r_old_hand  <= n_old_hand;
        r_had       <= n_had;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(NUM_SOURCES))
        else $error("heap count above number of sources");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_re && ram_we && ram_raddr == ram_waddr))
        else $error("heap ram read and write to the same slot in one cycle");

    a_wr_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CNTW'(ram_waddr) < r_count))
        else $error("heap ram write beyond the live entries");

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("response appeared outside the output step");

endmodule
